[sv/dam_pkg.sv]
// Package for the decimal accumulator machine.
// Holds opcodes, status codes, sequencer states, divider handshake types
// and the six-digit clamp helpers. No dependencies.
`default_nettype none
package dam_pkg;

    // payload widths
    localparam int DW = 21;
    localparam int MAGW = 20;
    localparam int OPDW = 10;

    localparam int MEM_WORDS_DEF = 250;

    // six-digit limit
    localparam logic signed [42:0] WORD_MAX = 43'sd999999;
    localparam logic signed [42:0] WORD_MIN = -43'sd999999;

    // reciprocal of 1000, scaled by 2**30
    localparam logic [40:0] RECIP_K = 41'd1073742;
    localparam int RECIP_S = 30;

    // item commands
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_EXEC = 2'd1;
    localparam logic [1:0] OP_SUPPLY = 2'd2;

    // opcodes
    localparam logic [OPDW-1:0] OPC_READ = 10'd10;
    localparam logic [OPDW-1:0] OPC_PRINT = 10'd11;
    localparam logic [OPDW-1:0] OPC_LOAD = 10'd20;
    localparam logic [OPDW-1:0] OPC_STORE = 10'd21;
    localparam logic [OPDW-1:0] OPC_ADD = 10'd30;
    localparam logic [OPDW-1:0] OPC_SUB = 10'd31;
    localparam logic [OPDW-1:0] OPC_DIV = 10'd32;
    localparam logic [OPDW-1:0] OPC_MUL = 10'd33;
    localparam logic [OPDW-1:0] OPC_BR = 10'd40;
    localparam logic [OPDW-1:0] OPC_BRNEG = 10'd41;
    localparam logic [OPDW-1:0] OPC_BRZERO = 10'd42;
    localparam logic [OPDW-1:0] OPC_HALT = 10'd43;

    // status codes
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_HALT = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_DIVZ = 3'd3;
    localparam logic [2:0] ST_ADDR = 3'd4;
    localparam logic [2:0] ST_SAT = 3'd5;
    localparam logic [2:0] ST_UNEXP = 3'd6;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_DEC1,
        S_DEC2,
        S_OPER,
        S_DATA,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic [MAGW-1:0] dividend;
        logic [MAGW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic [MAGW-1:0] quo;
    } t_div_rsp;

    // clamp to six digits
    function automatic logic signed [DW-1:0] f_clamp(input logic signed [42:0] v);
        if (v > WORD_MAX) begin
            return DW'(WORD_MAX);
        end else if (v < WORD_MIN) begin
            return DW'(WORD_MIN);
        end
        return DW'(v);
    endfunction

    function automatic logic f_over(input logic signed [42:0] v);
        return (v > WORD_MAX) || (v < WORD_MIN);
    endfunction

endpackage
`default_nettype wire

[sv/dam_if.sv]
// Handshake interfaces for the machine's input items and result items.
// Depends on dam_pkg for payload widths.
`default_nettype none
interface dam_in_if;
    import dam_pkg::*;
    logic valid;
    logic ready;
    logic [1:0] op;
    logic [7:0] load_address;
    logic signed [DW-1:0] data_word;
    modport source (output valid, output op, output load_address, output data_word,
                    input ready);
    modport sink (input valid, input op, input load_address, input data_word,
                  output ready);
endinterface

interface dam_out_if;
    import dam_pkg::*;
    logic valid;
    logic ready;
    logic [2:0] status;
    logic [7:0] pc_now;
    logic signed [DW-1:0] acc_now;
    logic print_valid;
    logic [7:0] print_address;
    logic signed [DW-1:0] print_value;
    modport source (output valid, output status, output pc_now, output acc_now,
                    output print_valid, output print_address, output print_value,
                    input ready);
    modport sink (input valid, input status, input pc_now, input acc_now,
                  input print_valid, input print_address, input print_value,
                  output ready);
endinterface
`default_nettype wire

[sv/dam_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module dam_ram #(
    parameter int W = 21,
    parameter int DEPTH = 250
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [W-1:0]               i_wdata,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [W-1:0]              o_rdata
);
    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[sv/dam_div.sv]
// Restoring divider on magnitudes, one quotient bit per cycle.
// Depends on dam_pkg for the request and response types.
`default_nettype none
module dam_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  dam_pkg::t_div_req   i_req,
    output dam_pkg::t_div_rsp   o_rsp
);
    import dam_pkg::*;

    localparam int CW = $clog2(MAGW);

    logic [MAGW-1:0] r_rem, n_rem;
    logic [MAGW-1:0] r_quo, n_quo;
    logic [MAGW-1:0] r_den;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [MAGW:0]   shifted;
    logic [MAGW:0]   diff;

    // one restoring step
    always_comb begin
        shifted = {r_rem, r_quo[MAGW-1]};
        diff = shifted - {1'b0, r_den};
        if (!diff[MAGW]) begin
            n_rem = diff[MAGW-1:0];
            n_quo = {r_quo[MAGW-2:0], 1'b1};
        end else begin
            n_rem = shifted[MAGW-1:0];
            n_quo = {r_quo[MAGW-2:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(MAGW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo = r_quo;
endmodule
`default_nettype wire

[sv/decimal_accumulator_machine_step.sv]
// Decimal accumulator machine: one item per write, execute or supply command.
// Writes and rejected items go from idle straight to done; instructions pass through fetch,
// decode and operand states, and divide waits on the divider (one quotient bit per cycle).
// One item in flight at a time; the word memory's single read port sets the pace.
// After reset a clearing pass zeroes every word of the memory; no items are taken meanwhile.
`default_nettype none
module decimal_accumulator_machine_step #(
    parameter int MEM_WORDS = dam_pkg::MEM_WORDS_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    dam_in_if.sink    i_in,
    dam_out_if.source o_out
);
    import dam_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [10:0] L_MEMW = 11'(MEM_WORDS);

    t_state r_state, n_state;
    logic [1:0] r_op, n_op;
    logic signed [DW-1:0] r_data, n_data;
    logic [AW-1:0] r_pc, n_pc;
    logic signed [DW-1:0] r_acc, n_acc;
    logic r_wait, n_wait;
    logic [MAGW-1:0] r_mag, n_mag;
    logic [OPDW-1:0] r_opc, n_opc;
    logic [OPDW-1:0] r_opd, n_opd;
    logic signed [41:0] r_prod, n_prod;
    logic r_dneg, n_dneg;
    logic [2:0] r_status, n_status;
    logic r_pv, n_pv;
    logic [7:0] r_paddr, n_paddr;
    logic signed [DW-1:0] r_pval, n_pval;
    logic [AW-1:0] r_clr, n_clr;
    logic r_ovalid, n_ovalid;
    logic [2:0] r_o_status;
    logic [7:0] r_o_pc;
    logic signed [DW-1:0] r_o_acc;
    logic r_o_pv;
    logic [7:0] r_o_paddr;
    logic signed [DW-1:0] r_o_pval;

    logic mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [DW-1:0] mem_wdata, mem_rdata;
    logic signed [DW-1:0] rword;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic accept, can_out, addr_ok, opd_ok, opc_known, imm_done, short_op;
    logic [AW:0] pc_inc;
    logic [AW-1:0] pc_next;
    logic [MAGW-1:0] dec_mag;
    logic [40:0] dec_prod;
    logic [MAGW-1:0] dec_qk;
    logic signed [42:0] wide;
    logic [MAGW-1:0] acc_mag, w_mag;

    dam_ram #(.W(DW), .DEPTH(MEM_WORDS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    dam_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // shared decode terms
    assign rword = mem_rdata;
    assign accept = i_in.valid && i_in.ready;
    assign can_out = !r_ovalid || o_out.ready;
    assign addr_ok = {3'b000, i_in.load_address} < L_MEMW;
    assign opd_ok = {1'b0, r_opd} < L_MEMW;
    assign pc_inc = {1'b0, r_pc} + 1'b1;
    assign pc_next = (pc_inc >= (AW+1)'(MEM_WORDS)) ? '0 : pc_inc[AW-1:0];
    assign opc_known = (r_opc == OPC_READ) || (r_opc == OPC_PRINT)
                    || (r_opc == OPC_LOAD) || (r_opc == OPC_STORE)
                    || (r_opc == OPC_ADD) || (r_opc == OPC_SUB)
                    || (r_opc == OPC_DIV) || (r_opc == OPC_MUL)
                    || (r_opc == OPC_BR) || (r_opc == OPC_BRNEG)
                    || (r_opc == OPC_BRZERO);
    assign imm_done = (i_in.op == OP_WRITE) || (i_in.op == 2'd3)
                   || ((i_in.op == OP_SUPPLY) && !r_wait)
                   || ((i_in.op == OP_EXEC) && r_wait);
    assign short_op = (r_op == OP_SUPPLY) || (r_opc == OPC_HALT) || !opc_known || !opd_ok
                   || (r_opc == OPC_READ) || (r_opc == OPC_STORE) || (r_opc == OPC_BR)
                   || (r_opc == OPC_BRNEG) || (r_opc == OPC_BRZERO);
    assign dec_mag = rword[DW-1] ? MAGW'(-rword) : MAGW'(rword);
    assign dec_prod = 41'(dec_mag) * RECIP_K;
    assign dec_qk = MAGW'(r_opc) * 20'd1000;
    assign acc_mag = r_acc[DW-1] ? MAGW'(-r_acc) : MAGW'(r_acc);
    assign w_mag = rword[DW-1] ? MAGW'(-rword) : MAGW'(rword);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(MEM_WORDS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = imm_done ? S_DONE : S_FETCH;
            end
            S_FETCH: n_state = S_DEC1;
            S_DEC1:  n_state = S_DEC2;
            S_DEC2:  n_state = S_OPER;
            S_OPER:  n_state = short_op ? S_DONE : S_DATA;
            S_DATA: begin
                if (r_opc == OPC_MUL) begin
                    n_state = S_MUL;
                end else if ((r_opc == OPC_DIV) && (rword != '0)) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL: n_state = S_DONE;
            S_DIV: begin
                if (div_rsp.done) n_state = S_DONE;
            end
            S_DONE: begin
                if (can_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_op = r_op;
        n_data = r_data;
        n_pc = r_pc;
        n_acc = r_acc;
        n_wait = r_wait;
        n_mag = r_mag;
        n_opc = r_opc;
        n_opd = r_opd;
        n_prod = r_prod;
        n_dneg = r_dneg;
        n_status = r_status;
        n_pv = r_pv;
        n_paddr = r_paddr;
        n_pval = r_pval;
        n_clr = r_clr;
        n_ovalid = r_ovalid && !o_out.ready;
        mem_we = 1'b0;
        mem_waddr = AW'(r_opd);
        mem_wdata = r_acc;
        mem_raddr = (r_state == S_FETCH) ? r_pc : AW'(r_opd);
        div_req.start = 1'b0;
        div_req.dividend = acc_mag;
        div_req.divisor = w_mag;
        wide = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (accept) begin
                    n_op = i_in.op;
                    n_data = i_in.data_word;
                    n_pv = 1'b0;
                    n_paddr = '0;
                    n_pval = '0;
                    n_status = ST_OK;
                    wide = 43'(i_in.data_word);
                    if (i_in.op == OP_WRITE) begin
                        if (addr_ok) begin
                            mem_we = 1'b1;
                            mem_waddr = AW'(i_in.load_address);
                            mem_wdata = f_clamp(wide);
                            n_status = f_over(wide) ? ST_SAT : ST_OK;
                        end else begin
                            n_status = ST_ADDR;
                        end
                    end else if (i_in.op == OP_EXEC) begin
                        if (r_wait) n_status = ST_WAIT;
                    end else if ((i_in.op != OP_SUPPLY) || !r_wait) begin
                        n_status = ST_UNEXP;
                    end
                end
            end
            S_DEC1: begin
                n_mag = dec_mag;
                n_opc = OPDW'(dec_prod >> RECIP_S);
            end
            S_DEC2: begin
                n_opd = OPDW'(r_mag - dec_qk);
            end
            S_OPER: begin
                wide = 43'(r_data);
                if (r_op == OP_SUPPLY) begin
                    if (opd_ok) begin
                        mem_we = 1'b1;
                        mem_wdata = f_clamp(wide);
                        n_wait = 1'b0;
                        n_pc = pc_next;
                        n_status = f_over(wide) ? ST_SAT : ST_OK;
                    end else begin
                        n_status = ST_ADDR;
                    end
                end else if (r_opc == OPC_HALT) begin
                    n_pc = '0;
                    n_status = ST_HALT;
                end else if (!opc_known) begin
                    n_pc = pc_next;
                end else if (!opd_ok) begin
                    n_status = ST_ADDR;
                end else if (r_opc == OPC_READ) begin
                    n_wait = 1'b1;
                    n_status = ST_WAIT;
                end else if (r_opc == OPC_STORE) begin
                    mem_we = 1'b1;
                    n_pc = pc_next;
                end else if (r_opc == OPC_BR) begin
                    n_pc = AW'(r_opd);
                end else if (r_opc == OPC_BRNEG) begin
                    n_pc = r_acc[DW-1] ? AW'(r_opd) : pc_next;
                end else if (r_opc == OPC_BRZERO) begin
                    n_pc = (r_acc == '0) ? AW'(r_opd) : pc_next;
                end
            end
            S_DATA: begin
                n_pc = pc_next;
                if (r_opc == OPC_PRINT) begin
                    n_pv = 1'b1;
                    n_paddr = 8'(r_opd);
                    n_pval = rword;
                end else if (r_opc == OPC_LOAD) begin
                    n_acc = rword;
                end else if ((r_opc == OPC_ADD) || (r_opc == OPC_SUB)) begin
                    wide = (r_opc == OPC_ADD) ? 43'(r_acc) + 43'(rword)
                                              : 43'(r_acc) - 43'(rword);
                    n_acc = f_clamp(wide);
                    n_status = f_over(wide) ? ST_SAT : ST_OK;
                end else if (r_opc == OPC_MUL) begin
                    n_prod = 42'(r_acc) * 42'(rword);
                end else if (rword == '0) begin
                    // divide by zero: hold pc
                    n_pc = r_pc;
                    n_status = ST_DIVZ;
                end else begin
                    div_req.start = 1'b1;
                    n_dneg = r_acc[DW-1] ^ rword[DW-1];
                end
            end
            S_MUL: begin
                wide = 43'(r_prod);
                n_acc = f_clamp(wide);
                n_status = f_over(wide) ? ST_SAT : ST_OK;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_acc = r_dneg ? -DW'(div_rsp.quo) : DW'(div_rsp.quo);
                end
            end
            S_DONE: begin
                if (can_out) n_ovalid = 1'b1;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_pc <= '0;
            r_acc <= '0;
            r_wait <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_pc <= n_pc;
            r_acc <= n_acc;
            r_wait <= n_wait;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_data <= n_data;
        r_mag <= n_mag;
        r_opc <= n_opc;
        r_opd <= n_opd;
        r_prod <= n_prod;
        r_dneg <= n_dneg;
        r_status <= n_status;
        r_pv <= n_pv;
        r_paddr <= n_paddr;
        r_pval <= n_pval;
        if ((r_state == S_DONE) && can_out) begin
            r_o_status <= r_status;
            r_o_pc <= 8'(r_pc);
            r_o_acc <= r_acc;
            r_o_pv <= r_pv;
            r_o_paddr <= r_paddr;
            r_o_pval <= r_pval;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.status = r_o_status;
    assign o_out.pc_now = r_o_pc;
    assign o_out.acc_now = r_o_acc;
    assign o_out.print_valid = r_o_pv;
    assign o_out.print_address = r_o_paddr;
    assign o_out.print_value = r_o_pval;

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_in.ready)
        else $error("item taken while another is in flight");

    // pc stays inside the memory
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_pc} < (AW+1)'(MEM_WORDS)))
        else $error("program counter out of range");

    // a printed word comes only with ok status
    a_print_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.print_valid) |-> (o_out.status == ST_OK))
        else $error("print with bad status");

    // accumulator stays within six digits
    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (43'(r_acc) <= WORD_MAX) && (43'(r_acc) >= WORD_MIN))
        else $error("accumulator out of range");

endmodule
`default_nettype wire

[test/decimal_accumulator_machine_step_test.sv]
// Self-checking testbench for the decimal accumulator machine step block.
// Drives write, execute and supply items and checks every result against a
// built-in predictor. Depends on dam_pkg, dam_if and the block itself.
`timescale 1ns / 1ps
module decimal_accumulator_machine_step_test;
    import dam_pkg::*;

    localparam int NWORDS = MEM_WORDS_DEF;
    localparam int LIMIT_CYCLES = 1000000;

    typedef struct {
        logic [1:0] op;
        logic [7:0] addr;
        logic signed [DW-1:0] data;
    } t_cmd;

    typedef struct {
        logic [2:0] status;
        logic [7:0] pc;
        logic signed [DW-1:0] acc;
        logic pv;
        logic [7:0] pa;
        logic signed [DW-1:0] pval;
    } t_res;

    // directed row: command plus an optional typed-in status
    typedef struct {
        t_cmd cmd;
        bit has_st;
        logic [2:0] st;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    dam_in_if in_ch();
    dam_out_if out_ch();

    decimal_accumulator_machine_step dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    // machine state mirror
    int words [NWORDS];
    int pc_m;
    int acc_m;
    bit wait_m;

    t_res exp_q[$];
    logic [2:0] typed_st_q[$];
    bit typed_has_q[$];
    int errors;
    int results_seen;
    int cycles;
    int n_sent;
    int st_hist [8];
    bit done_send;

    function automatic int sat6(input longint v, inout bit s);
        if (v > 999999) begin
            s = 1;
            return 999999;
        end
        if (v < -999999) begin
            s = 1;
            return -999999;
        end
        return int'(v);
    endfunction

    function automatic int nxt(input int p);
        return (p + 1 >= NWORDS) ? 0 : p + 1;
    endfunction

    // advance the mirror by one item and return the expected result
    function automatic t_res machine_step(input t_cmd c);
        t_res r;
        bit s;
        int w, mag, opc, opd, a;
        longint q;
        s = 0;
        r.pv = 0;
        r.pa = 0;
        r.pval = 0;
        r.status = ST_OK;
        a = int'(c.data);
        case (c.op)
            OP_WRITE: begin
                if (c.addr >= NWORDS) begin
                    r.status = ST_ADDR;
                end else begin
                    words[c.addr] = sat6(a, s);
                    r.status = s ? ST_SAT : ST_OK;
                end
            end
            OP_EXEC: begin
                w = words[pc_m];
                mag = w < 0 ? -w : w;
                opc = mag / 1000;
                opd = mag % 1000;
                if (wait_m) begin
                    r.status = ST_WAIT;
                end else if (opc == OPC_HALT) begin
                    pc_m = 0;
                    r.status = ST_HALT;
                end else if (!(opc inside {OPC_READ, OPC_PRINT, OPC_LOAD, OPC_STORE,
                        OPC_ADD, OPC_SUB, OPC_DIV, OPC_MUL, OPC_BR, OPC_BRNEG,
                        OPC_BRZERO})) begin
                    pc_m = nxt(pc_m);
                end else if (opd >= NWORDS) begin
                    r.status = ST_ADDR;
                end else begin
                    case (opc)
                        OPC_READ: begin
                            wait_m = 1;
                            r.status = ST_WAIT;
                        end
                        OPC_BR: pc_m = opd;
                        OPC_BRNEG: pc_m = acc_m < 0 ? opd : nxt(pc_m);
                        OPC_BRZERO: pc_m = acc_m == 0 ? opd : nxt(pc_m);
                        OPC_DIV: begin
                            if (words[opd] == 0) begin
                                r.status = ST_DIVZ;
                            end else begin
                                q = longint'(acc_m) / longint'(words[opd]);
                                acc_m = sat6(q, s);
                                pc_m = nxt(pc_m);
                            end
                        end
                        default: begin
                            case (opc)
                                OPC_PRINT: begin
                                    r.pv = 1;
                                    r.pa = 8'(opd);
                                    r.pval = DW'(words[opd]);
                                end
                                OPC_LOAD: acc_m = words[opd];
                                OPC_STORE: words[opd] = acc_m;
                                OPC_ADD: acc_m = sat6(longint'(acc_m) + words[opd], s);
                                OPC_SUB: acc_m = sat6(longint'(acc_m) - words[opd], s);
                                default: acc_m = sat6(longint'(acc_m) * words[opd], s);
                            endcase
                            pc_m = nxt(pc_m);
                        end
                    endcase
                    if (s) begin
                        r.status = ST_SAT;
                    end
                end
            end
            OP_SUPPLY: begin
                w = words[pc_m];
                mag = w < 0 ? -w : w;
                opd = mag % 1000;
                if (!wait_m) begin
                    r.status = ST_UNEXP;
                end else if (opd >= NWORDS) begin
                    r.status = ST_ADDR;
                end else begin
                    words[opd] = sat6(a, s);
                    wait_m = 0;
                    pc_m = nxt(pc_m);
                    r.status = s ? ST_SAT : ST_OK;
                end
            end
            default: r.status = ST_UNEXP;
        endcase
        r.pc = 8'(pc_m);
        r.acc = DW'(acc_m);
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) begin
            return 0;
        end
        if (k < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // hand one item to the block, waiting for its acceptance
    task automatic send_item(input t_cmd c, input bit has_st, input logic [2:0] st);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.op <= c.op;
        in_ch.load_address <= c.addr;
        in_ch.data_word <= c.data;
        exp_q.push_back(machine_step(c));
        typed_has_q.push_back(has_st);
        typed_st_q.push_back(st);
        n_sent++;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    function automatic t_cmd mk(input logic [1:0] op, input int addr, input int data);
        t_cmd c;
        c.op = op;
        c.addr = 8'(addr);
        c.data = DW'(data);
        return c;
    endfunction

    function automatic int rnd_word();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) begin
            return $urandom_range(0, 1) ? 999999 : -999999;
        end
        if (k == 1) begin
            return $urandom_range(0, 1) ? 1048575 : -1048576;
        end
        if (k < 4) begin
            return int'($urandom_range(0, 20)) - 10;
        end
        return int'($urandom_range(0, 1999998)) - 999999;
    endfunction

    // instruction with a mostly small operand so programs hit live words
    function automatic int rnd_instr();
        int opcs[12] = '{OPC_READ, OPC_PRINT, OPC_LOAD, OPC_STORE, OPC_ADD, OPC_SUB,
                         OPC_DIV, OPC_MUL, OPC_BR, OPC_BRNEG, OPC_BRZERO, OPC_HALT};
        int opc, opd, k;
        k = $urandom_range(0, 19);
        opc = (k == 0) ? $urandom_range(0, 999) : opcs[$urandom_range(0, 11)];
        if (opc == OPC_HALT && $urandom_range(0, 2) != 0) begin
            opc = OPC_ADD;
        end
        opd = ($urandom_range(0, 15) == 0) ? $urandom_range(NWORDS, 999)
            : $urandom_range(0, 31);
        k = opc * 1000 + opd;
        if (k > 999999) begin
            k = 999999;
        end
        return $urandom_range(0, 3) == 0 ? -k : k;
    endfunction

    // stimulus
    initial begin
        t_row rows[$];
        t_cmd c;
        int k, j, plen;
        in_ch.valid = 0;
        in_ch.op = OP_WRITE;
        in_ch.load_address = 0;
        in_ch.data_word = 0;
        i_rst_n = 0;
        errors = 0;
        cycles = 0;
        n_sent = 0;
        done_send = 0;
        results_seen = 0;
        foreach (words[i]) words[i] = 0;
        pc_m = 0;
        acc_m = 0;
        wait_m = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: zero word is a skip, then a small read, load, mul, div, sub, print, halt program
        rows.push_back('{mk(OP_EXEC, 0, 0), 1, ST_OK});
        rows.push_back('{mk(OP_SUPPLY, 0, 5), 1, ST_UNEXP});
        rows.push_back('{mk(2'd3, 255, -1), 1, ST_UNEXP});
        rows.push_back('{mk(OP_WRITE, 250, 7), 1, ST_ADDR});
        rows.push_back('{mk(OP_WRITE, 255, 7), 1, ST_ADDR});
        rows.push_back('{mk(OP_WRITE, 200, 1048575), 1, ST_SAT});
        rows.push_back('{mk(OP_WRITE, 201, -1048576), 1, ST_SAT});
        rows.push_back('{mk(OP_WRITE, 202, 0), 1, ST_OK});
        rows.push_back('{mk(OP_WRITE, 1, 10100), 1, ST_OK});
        rows.push_back('{mk(OP_WRITE, 2, -20200), 1, ST_OK});
        rows.push_back('{mk(OP_WRITE, 3, 33201), 1, ST_OK});
        rows.push_back('{mk(OP_WRITE, 4, 32201), 1, ST_OK});
        rows.push_back('{mk(OP_WRITE, 5, 31200), 0, 0});
        rows.push_back('{mk(OP_WRITE, 6, 11100), 0, 0});
        rows.push_back('{mk(OP_WRITE, 7, 43000), 0, 0});
        rows.push_back('{mk(OP_EXEC, 0, 0), 0, 0});
        rows.push_back('{mk(OP_EXEC, 0, 0), 1, ST_WAIT});
        rows.push_back('{mk(OP_EXEC, 0, 0), 1, ST_WAIT});
        rows.push_back('{mk(OP_SUPPLY, 0, -1048576), 1, ST_SAT});
        for (int i = 0; i < 5; i++) rows.push_back('{mk(OP_EXEC, 0, 0), 0, 0});
        rows.push_back('{mk(OP_EXEC, 0, 0), 1, ST_HALT});
        foreach (rows[i]) send_item(rows[i].cmd, rows[i].has_st, rows[i].st);

        // random: write a short program, run it, feed reads, with some noise
        while (n_sent < 1000 + rows.size()) begin
            plen = $urandom_range(3, 12);
            k = $urandom_range(0, NWORDS - 1 - plen);
            for (j = 0; j < plen; j++) begin
                send_item(mk(OP_WRITE, k + j, rnd_instr()), 0, 0);
            end
            for (j = 0; j < 4; j++) begin
                send_item(mk(OP_WRITE, $urandom_range(0, 31), rnd_word()), 0, 0);
            end
            if ($urandom_range(0, 1)) begin
                send_item(mk(OP_WRITE, $urandom_range(0, 255), rnd_word()), 0, 0);
            end
            // steer pc to the program through a branch word at the current pc
            send_item(mk(OP_WRITE, pc_m, int'(OPC_BR) * 1000 + k), 0, 0);
            if (!wait_m) begin
                send_item(mk(OP_EXEC, 0, 0), 0, 0);
            end
            for (j = 0; j < plen * 2; j++) begin
                k = $urandom_range(0, 15);
                if (wait_m && k < 12) begin
                    send_item(mk(OP_SUPPLY, $urandom_range(0, 255), rnd_word()), 0, 0);
                end else if (k == 15) begin
                    send_item(mk($urandom_range(0, 1) ? OP_SUPPLY : 2'd3,
                        $urandom_range(0, 255), rnd_word()), 0, 0);
                end else begin
                    send_item(mk(OP_EXEC, $urandom_range(0, 255), rnd_word()), 0, 0);
                end
            end
        end
        in_ch.valid <= 0;
        done_send = 1;
    end

    // result side: random stalls, compare with oldest expectation
    initial begin
        t_res e;
        logic [2:0] tst;
        bit th;
        bit bad;
        out_ch.ready = 0;
        foreach (st_hist[i]) st_hist[i] = 0;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 40) == 0) begin
                out_ch.ready <= 0;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
                out_ch.ready <= 1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 30) == 0);
            end
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                st_hist[out_ch.status]++;
                if (exp_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result status %0d", out_ch.status);
                end else begin
                    e = exp_q.pop_front();
                    th = typed_has_q.pop_front();
                    tst = typed_st_q.pop_front();
                    bad = (out_ch.status !== e.status) || (out_ch.pc_now !== e.pc)
                        || (out_ch.acc_now !== e.acc) || (out_ch.print_valid !== e.pv)
                        || (out_ch.print_address !== e.pa)
                        || (out_ch.print_value !== e.pval);
                    if (th && (out_ch.status !== tst)) bad = 1;
                    if (bad) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch #%0d: exp st=%0d pc=%0d acc=%0d pr=%0d/%0d/%0d",
                                results_seen, e.status, e.pc, e.acc, e.pv, e.pa, e.pval);
                            if (th) $display("             typed st=%0d", tst);
                            $display("             got st=%0d pc=%0d acc=%0d pr=%0d/%0d/%0d",
                                out_ch.status, out_ch.pc_now, out_ch.acc_now,
                                out_ch.print_valid, out_ch.print_address,
                                out_ch.print_value);
                        end
                    end
                end
            end
        end
    end

    // end of run: drain, allow the longest latency, then report
    initial begin
        wait (done_send);
        wait (exp_q.size() == 0);
        repeat (60) @(posedge i_clk);
        $display("ran %0d items; status counts ok=%0d halt=%0d wait=%0d divz=%0d",
            n_sent, st_hist[0], st_hist[1], st_hist[2], st_hist[3]);
        $display("addr=%0d sat=%0d unexpected=%0d; %0d mismatches",
            st_hist[4], st_hist[5], st_hist[6], errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
